/* design/kdeq_pkg.sv */
// Shared constants, types and helpers for the key debounce event queue.
`timescale 1ns / 1ps

package kdeq_pkg;

  localparam int RING_DEPTH = 16;
  localparam int IDX_W      = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int MAX_READ   = 16;
  localparam int CNT_W      = 5;
  localparam int CODE_W     = 8;
  localparam int CFG_W      = 8;
  localparam int CFG_IDX_W  = 2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PRESS    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE  = 2'd3;

  // Register reset values.
  localparam logic [CFG_W-1:0] DEBOUNCE_RST = 8'd10;
  localparam logic [CFG_W-1:0] PRESS_RST    = 8'd1;
  localparam logic [CFG_W-1:0] RELEASE_RST  = 8'd128;

  // Operation codes.
  localparam logic OP_SCAN = 1'b0;
  localparam logic OP_READ = 1'b1;

  // Kinds of result loaded into the output register.
  localparam logic [1:0] RES_CLOSED = 2'd0;
  localparam logic [1:0] RES_OK     = 2'd1;
  localparam logic [1:0] RES_EVENT  = 2'd2;

  typedef logic [IDX_W-1:0] idx_t;

  typedef struct packed {
    logic       scan;
    logic       rd_start;
    logic       pop;
    logic       load_out;
    logic [1:0] res_kind;
    logic       res_last;
  } kdeq_cmd_t;

  typedef struct packed {
    logic enable;
    logic empty;
    logic pop_last;
  } kdeq_sts_t;

  function automatic idx_t idx_inc(input idx_t idx);
    idx_t res;
    if (idx == idx_t'(RING_DEPTH - 1)) begin
      res = '0;
    end else begin
      res = idx + idx_t'(1);
    end
    return res;
  endfunction

endpackage

/* design/kdeq_ctrl.sv */
// Controller state machine: takes items, sequences reads and owns the output valid.
`timescale 1ns / 1ps

module kdeq_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_operation,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  kdeq_pkg::kdeq_sts_t  sts,
  output kdeq_pkg::kdeq_cmd_t  cmd
);
  import kdeq_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_POP  = 1'b1;

  logic state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic out_free;
  logic accept;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE) && out_free;
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd.load_out = 1'b1;
          cmd.res_last = 1'b1;
          if (!sts.enable) begin
            cmd.res_kind = RES_CLOSED;
          end else if (in_operation == OP_SCAN) begin
            cmd.scan     = 1'b1;
            cmd.res_kind = RES_OK;
          end else if (sts.empty) begin
            cmd.res_kind = RES_OK;
          end else begin
            // Events follow one a cycle from the pop state while the output is free.
            cmd.load_out = 1'b0;
            cmd.res_last = 1'b0;
            cmd.rd_start = 1'b1;
            state_nxt    = S_POP;
          end
        end
      end
      S_POP: begin
        if (out_free) begin
          cmd.pop      = 1'b1;
          cmd.load_out = 1'b1;
          cmd.res_kind = RES_EVENT;
          cmd.res_last = sts.pop_last;
          if (sts.pop_last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

/* design/kdeq_dp.sv */
// Datapath: configuration, debounce counter, event ring and output register.
`timescale 1ns / 1ps

module kdeq_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [kdeq_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [kdeq_pkg::CFG_W-1:0]        cfg_wdata,
  input  logic                              in_pin_level,
  input  logic [kdeq_pkg::CNT_W-1:0]        in_read_count,
  input  kdeq_pkg::kdeq_cmd_t               cmd,
  output kdeq_pkg::kdeq_sts_t               sts,
  output logic                              out_status,
  output logic                              out_event_valid,
  output logic [kdeq_pkg::CODE_W-1:0]       out_event_code,
  output logic                              out_last
);
  import kdeq_pkg::*;

  logic              enable_r;
  logic [CFG_W-1:0]  debounce_r;
  logic [CFG_W-1:0]  press_r;
  logic [CFG_W-1:0]  release_r;

  logic              stable_r, stable_nxt;
  logic              cand_r, cand_nxt;
  logic [7:0]        settle_r, settle_nxt;
  logic [7:0]        settle_base;
  logic [7:0]        settle_inc;
  logic              ev_wr;
  logic [CODE_W-1:0] ev_code;

  idx_t              wr_idx_r;
  idx_t              rd_idx_r;
  idx_t              rd_idx_inc;
  idx_t              rd_addr;
  logic [CODE_W-1:0] ring [RING_DEPTH];
  logic [CODE_W-1:0] rd_data_r;

  logic [CNT_W-1:0]  rem_r;
  logic [CNT_W-1:0]  want;

  logic              status_r;
  logic              ev_valid_r;
  logic [CODE_W-1:0] code_r;
  logic              last_r;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r   <= 1'b0;
      debounce_r <= DEBOUNCE_RST;
      press_r    <= PRESS_RST;
      release_r  <= RELEASE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ENABLE:   enable_r   <= cfg_wdata[0];
        REG_DEBOUNCE: debounce_r <= cfg_wdata;
        REG_PRESS:    press_r    <= cfg_wdata;
        REG_RELEASE:  release_r  <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // A change of the candidate restarts the count; a level that differs from
  // the stable one counts up until the threshold accepts it.
  always_comb begin
    settle_base = (in_pin_level != cand_r) ? 8'd0 : settle_r;
    settle_inc  = settle_base + 8'd1;
    cand_nxt    = in_pin_level;
    stable_nxt  = stable_r;
    settle_nxt  = settle_base;
    ev_wr       = 1'b0;
    ev_code     = in_pin_level ? (press_r + release_r) : press_r;
    if (in_pin_level != stable_r) begin
      if (settle_inc >= debounce_r) begin
        settle_nxt = 8'd0;
        ev_wr      = 1'b1;
        stable_nxt = in_pin_level;
      end else begin
        settle_nxt = settle_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stable_r <= 1'b1;
      cand_r   <= 1'b1;
      settle_r <= 8'd0;
    end else if (cmd.scan) begin
      stable_r <= stable_nxt;
      cand_r   <= cand_nxt;
      settle_r <= settle_nxt;
    end
  end

  // Ring indexes and read counter.
  assign rd_idx_inc = idx_inc(rd_idx_r);
  assign rd_addr    = cmd.pop ? rd_idx_inc : rd_idx_r;

  always_comb begin
    if (in_read_count == '0) begin
      want = CNT_W'(1);
    end else if (in_read_count > CNT_W'(MAX_READ)) begin
      want = CNT_W'(MAX_READ);
    end else begin
      want = in_read_count;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_idx_r <= '0;
      rd_idx_r <= '0;
      rem_r    <= '0;
    end else begin
      if (cmd.scan && ev_wr) begin
        wr_idx_r <= idx_inc(wr_idx_r);
      end
      if (cmd.pop) begin
        rd_idx_r <= rd_idx_inc;
        rem_r    <= rem_r - CNT_W'(1);
      end else if (cmd.rd_start) begin
        rem_r <= want;
      end
    end
  end

  // The read port always fetches the entry the next pop will need.
  always_ff @(posedge clk) begin
    if (cmd.scan && ev_wr) begin
      ring[wr_idx_r] <= ev_code;
    end
    rd_data_r <= ring[rd_addr];
  end

  assign sts.enable   = enable_r;
  assign sts.empty    = (rd_idx_r == wr_idx_r);
  assign sts.pop_last = (rem_r == CNT_W'(1)) || (rd_idx_inc == wr_idx_r);

  // Output register.
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      status_r   <= (cmd.res_kind == RES_CLOSED);
      ev_valid_r <= (cmd.res_kind == RES_EVENT);
      code_r     <= (cmd.res_kind == RES_EVENT) ? rd_data_r : '0;
      last_r     <= cmd.res_last;
    end
  end

  assign out_status      = status_r;
  assign out_event_valid = ev_valid_r;
  assign out_event_code  = code_r;
  assign out_last        = last_r;

endmodule

/* design/key_debounce_event_queue.sv */
// Top level of the key debounce event queue: controller plus datapath.
//
//   Channel  Direction  Handshake              Payload
//   in_      input      in_valid / in_ready    operation, pin_level, read_count
//   out_     output     out_valid / out_ready  status, event_valid, event_code, last
//   cfg_     input      cfg_we                 cfg_index, cfg_wdata
//
// A scan item, a closed-device item or a read of an empty queue gives one result.
// A read of queued events first loads the read counter, then gives the events
// one by one, set by the single ring read port, and takes no new item meanwhile.
// Reset (rst_n low, synchronous) empties the queue and restores every register but
// the ring data and output payload. A stalled output holds its result; the next item
// is taken in the cycle the waiting result leaves the output register.
`timescale 1ns / 1ps

module key_debounce_event_queue (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [kdeq_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [kdeq_pkg::CFG_W-1:0]      cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_operation,
  input  logic                            in_pin_level,
  input  logic [kdeq_pkg::CNT_W-1:0]      in_read_count,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_status,
  output logic                            out_event_valid,
  output logic [kdeq_pkg::CODE_W-1:0]     out_event_code,
  output logic                            out_last
);
  import kdeq_pkg::*;

  kdeq_cmd_t cmd;
  kdeq_sts_t sts;

  kdeq_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_operation (in_operation),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .sts          (sts),
    .cmd          (cmd)
  );

  kdeq_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_pin_level    (in_pin_level),
    .in_read_count   (in_read_count),
    .cmd             (cmd),
    .sts             (sts),
    .out_status      (out_status),
    .out_event_valid (out_event_valid),
    .out_event_code  (out_event_code),
    .out_last        (out_last)
  );

endmodule
